/* hw/rtl/tpe_pkg.sv */
// ----------------------------------------------------------------------------
// tpe_pkg: shared types and constants of the table product exponential
// Factor table, e and 1/e in Q2.62, and the handshake structs between the
// sequencer, the shared multiplier and the top level.
// ----------------------------------------------------------------------------
package tpe_pkg;

  localparam int TABLE_LEN_DEF = 25;
  localparam int MAX_ITERS_DEF = 32;
  localparam int ROM_DEPTH     = 32;
  localparam int CFG_W         = 6;

  typedef logic [63:0] word_t;
  typedef logic [ROM_DEPTH-1:0][63:0] factor_table_t;

  localparam word_t Q62_ONE  = 64'h4000_0000_0000_0000;
  localparam word_t WEIGHT0  = 64'h8000_0000_0000_0000;
  // floor(x / 3) = (x * RECIP3) >> 65 for any 64-bit x
  localparam word_t RECIP3   = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam logic [CFG_W-1:0] ITER_RESET = 6'd24;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic take;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_sts_t;

  // truncating division by a small constant, elaboration only
  function automatic word_t div_const(input word_t v, input int k);
    case (k)
      1:  div_const = v;
      2:  div_const = v / 64'd2;
      3:  div_const = v / 64'd3;
      4:  div_const = v / 64'd4;
      5:  div_const = v / 64'd5;
      6:  div_const = v / 64'd6;
      7:  div_const = v / 64'd7;
      8:  div_const = v / 64'd8;
      9:  div_const = v / 64'd9;
      10: div_const = v / 64'd10;
      11: div_const = v / 64'd11;
      12: div_const = v / 64'd12;
      13: div_const = v / 64'd13;
      14: div_const = v / 64'd14;
      15: div_const = v / 64'd15;
      16: div_const = v / 64'd16;
      17: div_const = v / 64'd17;
      18: div_const = v / 64'd18;
      19: div_const = v / 64'd19;
      20: div_const = v / 64'd20;
      21: div_const = v / 64'd21;
      22: div_const = v / 64'd22;
      23: div_const = v / 64'd23;
      24: div_const = v / 64'd24;
      25: div_const = v / 64'd25;
      26: div_const = v / 64'd26;
      27: div_const = v / 64'd27;
      28: div_const = v / 64'd28;
      29: div_const = v / 64'd29;
      30: div_const = v / 64'd30;
      31: div_const = v / 64'd31;
      32: div_const = v / 64'd32;
      33: div_const = v / 64'd33;
      34: div_const = v / 64'd34;
      35: div_const = v / 64'd35;
      36: div_const = v / 64'd36;
      37: div_const = v / 64'd37;
      38: div_const = v / 64'd38;
      39: div_const = v / 64'd39;
      40: div_const = v / 64'd40;
      default: div_const = '0;
    endcase
  endfunction

  // entry i: truncated series of e^(2^-(i+1)), stops at the first zero term
  function automatic factor_table_t build_factors();
    factor_table_t tbl;
    word_t         term;
    word_t         sum;
    logic          stop;
    for (int idx = 0; idx < ROM_DEPTH; idx++) begin
      sum  = Q62_ONE;
      term = Q62_ONE;
      stop = 1'b0;
      for (int k = 1; k <= 64; k++) begin
        if (!stop) begin
          term = div_const(term >> (idx + 1), k);
          if (term == '0) stop = 1'b1;
          else sum = sum + term;
        end
      end
      tbl[idx] = sum;
    end
    return tbl;
  endfunction

  // e, or 1/e from the alternating sums of the same terms
  function automatic word_t exp_series(input logic inverse);
    word_t term;
    word_t e_sum;
    word_t pos_sum;
    word_t neg_sum;
    term    = Q62_ONE;
    e_sum   = Q62_ONE;
    pos_sum = Q62_ONE;
    neg_sum = '0;
    for (int k = 1; k <= 40; k++) begin
      term  = div_const(term, k);
      e_sum = e_sum + term;
      if (k % 2 == 1) neg_sum = neg_sum + term;
      else pos_sum = pos_sum + term;
    end
    return inverse ? (pos_sum - neg_sum) : e_sum;
  endfunction

  localparam factor_table_t FACTORS   = build_factors();
  localparam word_t         E_Q62     = exp_series(1'b0);
  localparam word_t         INV_E_Q62 = exp_series(1'b1);

endpackage

/* hw/rtl/tpe_mul.sv */
// ----------------------------------------------------------------------------
// tpe_mul: shared 64x64 multiplier
// Full 128-bit product from four 32x32 partial products, one per cycle,
// each registered before it is added into the accumulator.
// ----------------------------------------------------------------------------
module tpe_mul (
  input  logic              clk,
  input  logic              rst,
  input  tpe_pkg::mul_req_t req,
  output tpe_pkg::mul_rsp_t rsp
);
  import tpe_pkg::*;

  localparam logic [2:0] PH_LAST = 3'd4;

  logic         busy;
  logic         done;
  logic [2:0]   ph;
  word_t        a_r;
  word_t        b_r;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_shifted;

  always_comb begin
    a_half = ph[1] ? a_r[63:32] : a_r[31:0];
    b_half = ph[0] ? b_r[63:32] : b_r[31:0];
    // weight of the partial product taken in the previous phase
    unique case (ph)
      3'd1:    pp_shifted = {64'b0, pp};
      3'd2,
      3'd3:    pp_shifted = {32'b0, pp, 32'b0};
      3'd4:    pp_shifted = {pp, 64'b0};
      default: pp_shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= '0;
    end else begin
      done <= busy && (ph == PH_LAST);
      if (req.start) begin
        busy <= 1'b1;
        ph   <= '0;
      end else if (busy) begin
        ph <= ph + 3'd1;
        if (ph == PH_LAST) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      acc <= '0;
    end else if (busy) begin
      pp  <= 64'(a_half) * 64'(b_half);
      acc <= acc + pp_shifted;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

/* hw/rtl/tpe_seq.sv */
// ----------------------------------------------------------------------------
// tpe_seq: sequencer of the table product exponential
// Walks the fraction weights, the Taylor residual and the integer powers of
// e, issuing every multiplication to the shared multiplier.
// ----------------------------------------------------------------------------
module tpe_seq #(
  parameter int TABLE_LEN = tpe_pkg::TABLE_LEN_DEF,
  parameter int MAX_ITERS = tpe_pkg::MAX_ITERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tpe_pkg::seq_ctl_t               ctl,
  input  logic signed [31:0]              x_value,
  input  logic [tpe_pkg::CFG_W-1:0]       iteration_count,
  output tpe_pkg::seq_sts_t               sts,
  output tpe_pkg::word_t                  exp_value,
  output logic                            saturated
);
  import tpe_pkg::*;

  localparam int IW = $clog2(MAX_ITERS + 1);
  localparam int RW = $clog2(ROM_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STEP  = 4'd1;
  localparam logic [3:0] S_WMUL  = 4'd2;
  localparam logic [3:0] S_DIV3  = 4'd3;
  localparam logic [3:0] S_RES1  = 4'd4;
  localparam logic [3:0] S_RES2  = 4'd5;
  localparam logic [3:0] S_RES3  = 4'd6;
  localparam logic [3:0] S_RES4  = 4'd7;
  localparam logic [3:0] S_EXP   = 4'd8;
  localparam logic [3:0] S_EWAIT = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]    state;
  word_t         z;
  word_t         fx;
  word_t         ai;
  word_t         weight;
  logic [IW-1:0] i;
  logic [IW-1:0] n_lim;
  logic [5:0]    cnt;
  logic          pos;
  logic          sat;

  mul_req_t req;
  mul_rsp_t rsp;
  word_t    zq;
  word_t    q62;
  logic     over;
  word_t    ai_cur;
  logic     take_w;
  logic     x_pos;

  tpe_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    zq     = z >> 2;
    q62    = rsp.prod[125:62];
    over   = |rsp.prod[127:126];
    ai_cur = (int'(i) < TABLE_LEN) ? FACTORS[RW'(i)]
                                   : Q62_ONE + ((ai - Q62_ONE) >> 1);
    take_w = weight < z;
    x_pos  = !x_value[31] && (|x_value[30:26]);
    req    = '0;
    unique case (state)
      S_STEP: begin
        if (i == n_lim) begin
          req.start = 1'b1;
          req.a     = zq;
          req.b     = RECIP3;
        end else if (take_w) begin
          req.start = 1'b1;
          req.a     = fx;
          req.b     = ai_cur;
        end
      end
      S_DIV3: begin
        req.start = rsp.done;
        req.a     = {1'b0, rsp.prod[127:65]};
        req.b     = Q62_ONE + (zq >> 2);
      end
      S_RES1: begin
        req.start = rsp.done;
        req.a     = zq >> 1;
        req.b     = Q62_ONE + q62;
      end
      S_RES2: begin
        req.start = rsp.done;
        req.a     = zq;
        req.b     = Q62_ONE + q62;
      end
      S_RES3: begin
        req.start = rsp.done;
        req.a     = fx;
        req.b     = Q62_ONE + q62;
      end
      S_EXP: begin
        req.start = (cnt != '0);
        req.a     = fx;
        req.b     = pos ? E_Q62 : INV_E_Q62;
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sat   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            z      <= {x_value[25:0], 38'b0};
            fx     <= Q62_ONE;
            ai     <= Q62_ONE;
            weight <= WEIGHT0;
            i      <= '0;
            n_lim  <= (iteration_count > CFG_W'(MAX_ITERS)) ? IW'(MAX_ITERS)
                                                          : IW'(iteration_count);
            pos    <= x_pos;
            cnt    <= x_pos ? x_value[31:26] : 6'd0 - x_value[31:26];
            sat    <= 1'b0;
            state  <= S_STEP;
          end
        end
        S_STEP: begin
          if (i == n_lim) begin
            state <= S_DIV3;
          end else begin
            ai     <= ai_cur;
            weight <= weight >> 1;
            i      <= i + 1'b1;
            if (take_w) begin
              z     <= z - weight;
              state <= S_WMUL;
            end
          end
        end
        S_WMUL: begin
          if (rsp.done) begin
            fx    <= q62;
            state <= S_STEP;
          end
        end
        S_DIV3: if (rsp.done) state <= S_RES1;
        S_RES1: if (rsp.done) state <= S_RES2;
        S_RES2: if (rsp.done) state <= S_RES3;
        S_RES3: if (rsp.done) state <= S_RES4;
        S_RES4: begin
          if (rsp.done) begin
            fx    <= pos ? (q62 >> 22) : q62;
            state <= S_EXP;
          end
        end
        S_EXP: begin
          if (cnt == '0) begin
            if (!pos) fx <= fx >> 22;
            state <= S_DONE;
          end else begin
            state <= S_EWAIT;
          end
        end
        S_EWAIT: begin
          if (rsp.done) begin
            if (pos && over) begin
              sat <= 1'b1;
              fx  <= '1;
              cnt <= '0;
            end else begin
              fx  <= q62;
              cnt <= cnt - 6'd1;
            end
            state <= S_EXP;
          end
        end
        S_DONE: if (ctl.take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sts.idle  = (state == S_IDLE);
  assign sts.done  = (state == S_DONE);
  assign exp_value = fx;
  assign saturated = sat;

endmodule

/* hw/rtl/table_product_exponential.sv */
// ----------------------------------------------------------------------------
// table_product_exponential: exp(x) by a product of table factors
// Signed Q5.26 argument in, unsigned Q24.40 exp(x) out with a saturation
// flag; fraction weights, Taylor residual and powers of e on one multiplier.
//
// s_axis carries x, m_axis carries exp(x) in tdata and the saturation flag in
// tuser. cfg writes iteration_count (reset 24, values above MAX_ITERS act as
// MAX_ITERS); write it only while the block is idle. cfg_ready is always high.
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// Every multiplication goes through the shared 64x64 multiplier as four 32x32
// partial products. The result sits in an output register: a new transfer is
// accepted while it waits, and the sequencer holds its next result until
// m_axis_tready frees it. Reset clears the handshakes and restores
// iteration_count; no other pass.
// ----------------------------------------------------------------------------
module table_product_exponential #(
  parameter int TABLE_LEN = tpe_pkg::TABLE_LEN_DEF,
  parameter int MAX_ITERS = tpe_pkg::MAX_ITERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tpe_pkg::CFG_W-1:0] cfg_data,       // iteration_count
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic signed [31:0]        s_axis_tdata,   // x_value
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [63:0]               m_axis_tdata,   // exp_value
  output logic                      m_axis_tuser    // saturated
);
  import tpe_pkg::*;

  logic [CFG_W-1:0] iteration_count;
  seq_ctl_t         seq_ctl;
  seq_sts_t         seq_sts;
  word_t            seq_exp;
  logic             seq_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iteration_count <= cfg_data;
    end
  end

  assign s_axis_tready = seq_sts.idle;
  assign seq_ctl.start = s_axis_tvalid && s_axis_tready;
  assign seq_ctl.take  = seq_sts.done && (!m_axis_tvalid || m_axis_tready);

  tpe_seq #(
    .TABLE_LEN (TABLE_LEN),
    .MAX_ITERS (MAX_ITERS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .ctl             (seq_ctl),
    .x_value         (s_axis_tdata),
    .iteration_count (iteration_count),
    .sts             (seq_sts),
    .exp_value       (seq_exp),
    .saturated       (seq_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (seq_ctl.take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_ctl.take) begin
      m_axis_tdata <= seq_exp;
      m_axis_tuser <= seq_sat;
    end
  end

  // a transfer in starts the sequencer, which drops ready the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    seq_ctl.start |=> !s_axis_tready)
    else $error("sequencer still idle after an input transfer");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> &m_axis_tdata)
    else $error("saturated result is not clamped to all ones");

  a_idle_after_take: assert property (@(posedge clk) disable iff (rst)
    seq_ctl.take |=> s_axis_tready)
    else $error("sequencer not idle after handing over its result");

  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    seq_ctl.take |-> seq_sts.done && !(m_axis_tvalid && !m_axis_tready))
    else $error("result handed over into a full output register");

endmodule

/* verif/tpe_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpe_monitor: result predictor and comparator for table_product_exponential
// Watches the config, input and result channels. It keeps its own copy of
// iteration_count and of the factor table, e and 1/e. For every input
// transfer it computes the expected exp(x) and saturation flag. It compares
// every result transfer, in order, against the oldest prediction still held.
// ----------------------------------------------------------------------------
module tpe_monitor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [tpe_pkg::CFG_W-1:0] cfg_data,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // x_value
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [63:0]               m_axis_tdata,   // exp_value
  input  logic                      m_axis_tuser,   // saturated
  output int                        error_count,
  output int                        pending_count
);
  import tpe_pkg::*;

  localparam int FACTOR_COUNT = TABLE_LEN_DEF;
  localparam int ITER_CAP     = MAX_ITERS_DEF;

  typedef struct packed {
    logic [63:0] value;
    logic        sat;
  } exp_result_t;

  word_t            factor_rom [FACTOR_COUNT];
  word_t            e_const;
  word_t            inv_e_const;
  logic [CFG_W-1:0] iter_count;
  exp_result_t      exp_pending_q [$];

  initial begin : build_constants
    word_t term;
    word_t acc;
    word_t pos;
    word_t neg;
    int    k;
    for (int i = 0; i < FACTOR_COUNT; i++) begin
      acc  = Q62_ONE;
      term = Q62_ONE;
      k    = 1;
      while (k <= 64) begin
        term = (term >> (i + 1)) / word_t'(k);
        if (term == '0) begin
          k = 65;
        end else begin
          acc = acc + term;
          k++;
        end
      end
      factor_rom[i] = acc;
    end
    term    = Q62_ONE;
    e_const = Q62_ONE;
    pos     = Q62_ONE;
    neg     = '0;
    for (int j = 1; j <= 40; j++) begin
      term    = term / word_t'(j);
      e_const = e_const + term;
      if (j % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    inv_e_const = pos - neg;
  end

  // q2.62 product, top bit flags bits lost above 64
  function automatic logic [64:0] mul_q62(input word_t a, input word_t b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return {|p[127:126], p[125:62]};
  endfunction

  function automatic exp_result_t predict_exp(input logic [31:0] x,
                                              input logic [CFG_W-1:0] iters);
    int          x_int;
    int          n;
    word_t       z;
    word_t       zq;
    word_t       fx;
    word_t       ai;
    word_t       t;
    word_t       weight;
    logic [64:0] m;
    exp_result_t r;
    x_int = $signed(x[31:26]);
    z     = {x[25:0], 38'd0};
    n     = (iters > ITER_CAP) ? ITER_CAP : int'(iters);
    fx    = Q62_ONE;
    ai    = Q62_ONE;
    for (int i = 0; i < n; i++) begin
      weight = 64'd1 << (63 - i);
      if (i < FACTOR_COUNT) ai = factor_rom[i];
      else ai = Q62_ONE + ((ai - Q62_ONE) >> 1);
      if (weight < z) begin
        m  = mul_q62(fx, ai);
        fx = m[63:0];
        z  = z - weight;
      end
    end
    // taylor residual on the leftover fraction
    zq = z >> 2;
    t  = Q62_ONE + zq / word_t'(4);
    m  = mul_q62(zq / word_t'(3), t);
    t  = Q62_ONE + m[63:0];
    m  = mul_q62(zq / word_t'(2), t);
    t  = Q62_ONE + m[63:0];
    m  = mul_q62(zq, t);
    t  = Q62_ONE + m[63:0];
    m  = mul_q62(fx, t);
    fx = m[63:0];
    r.sat = 1'b0;
    if (x_int <= 0) begin
      for (int i = 0; i < -x_int; i++) begin
        m  = mul_q62(fx, inv_e_const);
        fx = m[63:0];
      end
      r.value = fx >> 22;
    end else begin
      r.value = fx >> 22;
      for (int i = 0; i < x_int; i++) begin
        if (!r.sat) begin
          m = mul_q62(r.value, e_const);
          if (m[64]) begin
            r.sat   = 1'b1;
            r.value = '1;
          end else begin
            r.value = m[63:0];
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    exp_result_t want;
    if (rst) begin
      iter_count = ITER_RESET;
      exp_pending_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_pending_q.size() == 0) begin
          $error("unexpected result transfer: exp_value %h saturated %b",
                 m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          want = exp_pending_q.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("exp_value mismatch: expected %h, actual %h", want.value, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tuser !== want.sat) begin
            $error("saturated mismatch: expected %b, actual %b", want.sat, m_axis_tuser);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        exp_pending_q.push_back(predict_exp(s_axis_tdata, iter_count));
      if (cfg_valid && cfg_ready)
        iter_count = cfg_data;
    end
    pending_count = exp_pending_q.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for table_product_exponential
// Drives x arguments and iteration_count writes, and stalls the result side.
// Runs a directed set of edge arguments and register extremes, then random
// phases with and without idle cycles on either side. The monitor checks
// every result; the verdict comes from its error and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import tpe_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 500;
  localparam int PHASE_ITEMS   = 170;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [63:0]      m_axis_tdata;
  logic             m_axis_tuser;
  int               error_count;
  int               pending_count;
  int               send_gap_pct = 0;
  int               stall_pct = 0;
  int               cycle_count = 0;
  logic [31:0]      directed_x [0:16];

  table_product_exponential u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tpe_monitor u_monitor (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_x(input logic [31:0] x);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the input side until every predicted result has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  task automatic write_iters(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_x();
    logic [31:0] x;
    int          pick;
    pick = $urandom_range(0, 99);
    x    = $urandom;
    if (pick >= 90) begin
      // around the saturation threshold
      x[31:26] = 6'($urandom_range(14, 17));
    end else if (pick >= 80) begin
      // fractions made of one or two halving weights, equality cases
      x[25:0] = (26'd1 << $urandom_range(0, 25)) |
                ($urandom_range(0, 1) ? (26'd1 << $urandom_range(0, 25)) : 26'd0);
    end else if (pick >= 60) begin
      x[31:26] = 6'($urandom_range(0, 6) - 3);
    end
    return x;
  endfunction

  task automatic run_random(input int count, input int gap, input int stall,
                            input logic [CFG_W-1:0] iters);
    write_iters(iters);
    send_gap_pct = gap;
    stall_pct    = stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 59) == 0) drain_results();
      send_x(random_x());
    end
  endtask

  initial begin
    directed_x = '{32'h0000_0000, 32'h0400_0000, 32'hFC00_0000, 32'h0200_0000,
                   32'h0100_0000, 32'h0300_0000, 32'h0000_0001, 32'h03FF_FFFF,
                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                   32'h4280_0000, 32'h4290_0000, 32'h4400_0000, 32'h9400_0000,
                   32'h5555_5555};
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (directed_x[i]) send_x(directed_x[i]);
    write_iters(6'd0);
    send_x(32'h03FF_FFFF);
    send_x(32'hAAAA_AAAA);
    send_x(32'h0200_0000);
    write_iters(6'd63);
    send_x(32'h03FF_FFFF);
    send_x(32'hC155_5555);
    send_x(32'h0000_0001);

    run_random(PHASE_ITEMS, 0, 0, 6'd32);
    run_random(PHASE_ITEMS, 48, 0, 6'd1);
    run_random(PHASE_ITEMS, 0, 48, 6'($urandom_range(2, 31)));
    run_random(PHASE_ITEMS, 12, 12, 6'd33);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* table_product_exponential.f */
hw/rtl/tpe_pkg.sv
hw/rtl/tpe_mul.sv
hw/rtl/tpe_seq.sv
hw/rtl/table_product_exponential.sv
verif/tpe_monitor.sv
verif/tb.sv
